// File: design/egd_pkg.sv
`default_nettype none

package egd_pkg;

    // Fixed field widths
    localparam int WINDOW_BITS     = 32;
    localparam int MAX_PREFIX_DEF  = 15;
    localparam int VALUE_BITS      = 17;
    localparam int LEN_BITS        = 5;
    localparam int CAT_BITS        = 2;

    // Mapping modes
    typedef enum logic [1:0] {
        OP_UE = 2'd0,
        OP_SE = 2'd1,
        OP_ME = 2'd2,
        OP_TE = 2'd3
    } t_op;

    // Chroma array types that select the large coded-block-pattern table
    localparam logic [CAT_BITS-1:0] CAT_420   = 2'd1;
    localparam logic [CAT_BITS-1:0] CAT_422   = 2'd2;
    localparam logic [CAT_BITS-1:0] CAT_RESET = CAT_420;

    // Table sizes
    localparam int CBP_BIG   = 48;
    localparam int CBP_SMALL = 16;

    typedef struct packed {
        t_op                    op;
        logic [WINDOW_BITS-1:0] bit_window;
        logic                   is_inter;
        logic                   te_single_bit;
    } t_eg_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [LEN_BITS-1:0]          code_length;
        logic                         error;
    } t_eg_result;

    // Coded-block-pattern maps, intra and inter columns
    localparam logic [5:0] CBP48_INTRA [CBP_BIG] = '{
        6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
        6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
        6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
        6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
        6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
    };

    localparam logic [5:0] CBP48_INTER [CBP_BIG] = '{
        6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
        6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
        6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
        6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
        6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41
    };

    localparam logic [3:0] CBP16_INTRA [CBP_SMALL] = '{
        4'd15, 4'd0, 4'd7,  4'd11, 4'd13, 4'd14, 4'd3, 4'd5,
        4'd10, 4'd12, 4'd1, 4'd2,  4'd4,  4'd8,  4'd6, 4'd9
    };

    localparam logic [3:0] CBP16_INTER [CBP_SMALL] = '{
        4'd0, 4'd1,  4'd2, 4'd4,  4'd8,  4'd3,  4'd5, 4'd10,
        4'd12, 4'd15, 4'd7, 4'd11, 4'd13, 4'd14, 4'd6, 4'd9
    };

endpackage

`default_nettype wire

// File: design/exp_golomb_codeword_decoder_top.sv
`default_nettype none

// Exp-Golomb codeword decoder (ue/se/me/te), one codeword per item.
// Pipeline: input register, then leading-zero count and table lookup into the result
// register, which drives o_strobe and o_result.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset (synchronous, active low) clears the valid flags and sets chroma_array_type to 1.

module exp_golomb_codeword_decoder_top #(
    parameter int MAX_PREFIX = egd_pkg::MAX_PREFIX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire egd_pkg::t_eg_item             i_item,
    output logic                               o_strobe,
    output egd_pkg::t_eg_result                o_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [egd_pkg::CAT_BITS-1:0]  i_cfg_data
);
    import egd_pkg::*;

    logic [CAT_BITS-1:0] r_cat;
    logic                r_in_valid;
    t_eg_item            r_in;
    logic                r_out_valid;
    t_eg_result          r_out;
    t_eg_result          n_out;
    logic                accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cat <= CAT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cat <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    egd_decode #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_decode (
        .i_item              (r_in),
        .i_chroma_array_type (r_cat),
        .o_result            (n_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: design/egd_decode.sv
`default_nettype none

module egd_decode #(
    parameter int MAX_PREFIX = egd_pkg::MAX_PREFIX_DEF
) (
    input  wire egd_pkg::t_eg_item             i_item,
    input  wire logic [egd_pkg::CAT_BITS-1:0]  i_chroma_array_type,
    output egd_pkg::t_eg_result                o_result
);
    import egd_pkg::*;

    localparam int ZW = $clog2(WINDOW_BITS + 1);
    localparam int LW = ZW + 1;

    logic [ZW-1:0]          zeros;
    logic [LW-1:0]          len;
    logic [LW-1:0]          shamt;
    logic [WINDOW_BITS-1:0] shifted;
    logic [VALUE_BITS-1:0]  code_num;
    logic [VALUE_BITS-1:0]  k_half;
    logic                   prefix_err;
    logic                   big_table;
    logic [VALUE_BITS-1:0]  me_val;
    logic                   me_err;

    // Leading-zero count: highest set bit wins
    always_comb begin
        zeros = ZW'(WINDOW_BITS);
        for (int i = 0; i < WINDOW_BITS; i++) begin
            if (i_item.bit_window[i]) begin
                zeros = ZW'(WINDOW_BITS - 1 - i);
            end
        end
    end

    // Codeword length, prefix check, codeNum = (top len bits) - 1
    assign len        = {zeros, 1'b1};
    assign prefix_err = (zeros > ZW'(MAX_PREFIX)) || (len > LW'(WINDOW_BITS));
    assign shamt      = LW'(WINDOW_BITS) - len;
    assign shifted    = i_item.bit_window >> shamt;
    assign code_num   = VALUE_BITS'(shifted) - VALUE_BITS'(1);
    assign k_half     = code_num >> 1;

    // me mapping through the coded-block-pattern table
    assign big_table = (i_chroma_array_type == CAT_420) || (i_chroma_array_type == CAT_422);

    always_comb begin
        me_val = '0;
        me_err = 1'b0;
        if (big_table) begin
            if (code_num > VALUE_BITS'(CBP_BIG - 1)) begin
                me_err = 1'b1;
            end else if (i_item.is_inter) begin
                me_val = VALUE_BITS'(CBP48_INTER[code_num[5:0]]);
            end else begin
                me_val = VALUE_BITS'(CBP48_INTRA[code_num[5:0]]);
            end
        end else begin
            if (code_num > VALUE_BITS'(CBP_SMALL - 1)) begin
                me_err = 1'b1;
            end else if (i_item.is_inter) begin
                me_val = VALUE_BITS'(CBP16_INTER[code_num[3:0]]);
            end else begin
                me_val = VALUE_BITS'(CBP16_INTRA[code_num[3:0]]);
            end
        end
    end

    // Mode select
    always_comb begin
        o_result.value       = '0;
        o_result.code_length = '0;
        o_result.error       = 1'b0;
        if (i_item.op == OP_TE && i_item.te_single_bit) begin
            // one-bit range: inverted first bit
            o_result.value       = {{(VALUE_BITS-1){1'b0}}, ~i_item.bit_window[WINDOW_BITS-1]};
            o_result.code_length = LEN_BITS'(1);
        end else if (prefix_err) begin
            o_result.error = 1'b1;
        end else begin
            unique case (i_item.op) inside
                OP_SE: begin
                    o_result.code_length = len[LEN_BITS-1:0];
                    if (code_num[0]) begin
                        o_result.value = k_half + VALUE_BITS'(1);
                    end else begin
                        o_result.value = VALUE_BITS'(0) - k_half;
                    end
                end
                OP_ME: begin
                    if (me_err) begin
                        o_result.error = 1'b1;
                    end else begin
                        o_result.value       = me_val;
                        o_result.code_length = len[LEN_BITS-1:0];
                    end
                end
                OP_UE, OP_TE: begin
                    o_result.value       = code_num;
                    o_result.code_length = len[LEN_BITS-1:0];
                end
                default: begin
                    o_result.error = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import egd_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    // Coded-block-pattern maps, {intra, inter} per code number
    localparam logic [11:0] CBP_PAIRS48 [48] = '{
        {6'd47, 6'd0},  {6'd31, 6'd16}, {6'd15, 6'd1},  {6'd0, 6'd2},
        {6'd23, 6'd4},  {6'd27, 6'd8},  {6'd29, 6'd32}, {6'd30, 6'd3},
        {6'd7, 6'd5},   {6'd11, 6'd10}, {6'd13, 6'd12}, {6'd14, 6'd15},
        {6'd39, 6'd47}, {6'd43, 6'd7},  {6'd45, 6'd11}, {6'd46, 6'd13},
        {6'd16, 6'd14}, {6'd3, 6'd6},   {6'd5, 6'd9},   {6'd10, 6'd31},
        {6'd12, 6'd35}, {6'd19, 6'd37}, {6'd21, 6'd42}, {6'd26, 6'd44},
        {6'd28, 6'd33}, {6'd35, 6'd34}, {6'd37, 6'd36}, {6'd42, 6'd40},
        {6'd44, 6'd39}, {6'd1, 6'd43},  {6'd2, 6'd45},  {6'd4, 6'd46},
        {6'd8, 6'd17},  {6'd17, 6'd18}, {6'd18, 6'd20}, {6'd20, 6'd24},
        {6'd24, 6'd19}, {6'd6, 6'd21},  {6'd9, 6'd26},  {6'd22, 6'd28},
        {6'd25, 6'd23}, {6'd32, 6'd27}, {6'd33, 6'd29}, {6'd34, 6'd30},
        {6'd36, 6'd22}, {6'd40, 6'd25}, {6'd38, 6'd38}, {6'd41, 6'd41}
    };

    localparam logic [7:0] CBP_PAIRS16 [16] = '{
        {4'd15, 4'd0}, {4'd0, 4'd1},   {4'd7, 4'd2},   {4'd11, 4'd4},
        {4'd13, 4'd8}, {4'd14, 4'd3},  {4'd3, 4'd5},   {4'd5, 4'd10},
        {4'd10, 4'd12}, {4'd12, 4'd15}, {4'd1, 4'd7},  {4'd2, 4'd11},
        {4'd4, 4'd13}, {4'd8, 4'd14},  {4'd6, 4'd6},   {4'd9, 4'd9}
    };

    // Decoder mirror plus queue of codewords still owed by the block
    class codeword_checker;
        logic [CAT_BITS-1:0] chroma_type;
        t_eg_result          pending_codes[$];
        int                  errors;

        function t_eg_result decode_codeword(t_eg_item it);
            int          zeros;
            int          len;
            logic [31:0] win;
            logic [31:0] suffix;
            logic [31:0] code_num;
            t_eg_result  r;
            r = '0;
            win = it.bit_window;
            // one-bit te range: inverted first bit, nothing else read
            if (it.op == OP_TE && it.te_single_bit) begin
                r.value = {16'd0, ~win[WINDOW_BITS-1]};
                r.code_length = 5'd1;
                return r;
            end
            zeros = 0;
            while (zeros < WINDOW_BITS && !win[WINDOW_BITS-1-zeros])
                zeros++;
            len = 2 * zeros + 1;
            if (zeros > MAX_PREFIX_DEF || len > WINDOW_BITS) begin
                r.error = 1'b1;
                return r;
            end
            suffix = (win >> (WINDOW_BITS - len)) & ((32'd1 << zeros) - 32'd1);
            code_num = (32'd1 << zeros) - 32'd1 + suffix;
            case (it.op)
                OP_SE: begin
                    if (code_num[0])
                        r.value = 17'((code_num + 32'd1) >> 1);
                    else
                        r.value = 17'd0 - 17'(code_num >> 1);
                end
                OP_ME: begin
                    if (chroma_type == CAT_420 || chroma_type == CAT_422) begin
                        if (code_num > 47) begin
                            r.error = 1'b1;
                            return r;
                        end
                        r.value = it.is_inter ? 17'(CBP_PAIRS48[code_num][5:0])
                                              : 17'(CBP_PAIRS48[code_num][11:6]);
                    end else begin
                        if (code_num > 15) begin
                            r.error = 1'b1;
                            return r;
                        end
                        r.value = it.is_inter ? 17'(CBP_PAIRS16[code_num][3:0])
                                              : 17'(CBP_PAIRS16[code_num][7:4]);
                    end
                end
                default: r.value = 17'(code_num);
            endcase
            r.code_length = 5'(len);
            return r;
        endfunction

        function void note_item(t_eg_item it);
            pending_codes.push_back(decode_codeword(it));
        endfunction

        function void check_result(t_eg_result got);
            t_eg_result want;
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected result value %0d len %0d err %0d",
                         $time, got.value, got.code_length, got.error);
                errors++;
                return;
            end
            want = pending_codes.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value expected %0d got %0d", $time, want.value, got.value);
                errors++;
            end
            if (got.code_length !== want.code_length) begin
                $display("%0t: code_length expected %0d got %0d",
                         $time, want.code_length, got.code_length);
                errors++;
            end
            if (got.error !== want.error) begin
                $display("%0t: error expected %0d got %0d", $time, want.error, got.error);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_eg_item            i_item;
    logic                o_strobe;
    t_eg_result          o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CAT_BITS-1:0] i_cfg_data;

    codeword_checker sb;
    int              idle_cycles;
    logic            no_gaps;

    exp_golomb_codeword_decoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_result);
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[exp_golomb_codeword_decoder_top] ERROR");
            $finish;
        end
    end

    function automatic t_eg_item make_item(t_op op, logic [31:0] win, logic inter,
                                           logic te1);
        t_eg_item it;
        it.op = op;
        it.bit_window = win;
        it.is_inter = inter;
        it.te_single_bit = te1;
        return it;
    endfunction

    // Window with a z-bit zero prefix, marker, random suffix and tail
    function automatic logic [31:0] prefixed_window(int z);
        logic [31:0] win;
        win = $urandom;
        if (z >= WINDOW_BITS)
            return '0;
        win = win & (32'hFFFF_FFFF >> z);
        win[WINDOW_BITS-1-z] = 1'b1;
        return win;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(t_eg_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    // Stop sending and let every owed result arrive
    task automatic drain();
        start = 1'b0;
        while (sb.pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_chroma(logic [CAT_BITS-1:0] cat);
        i_cfg_valid = 1'b1;
        i_cfg_data = cat;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.chroma_type = cat;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_items(int count);
        int          pick;
        int          z;
        logic [31:0] win;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 6)
                z = $urandom_range(16, 32);
            else if (pick < 70)
                z = $urandom_range(0, 5);
            else
                z = $urandom_range(6, 15);
            win = (pick < 2) ? 32'($urandom) : prefixed_window(z);
            send_item(make_item(t_op'($urandom_range(0, 3)), win, 1'($urandom),
                                1'($urandom)));
            if ($urandom_range(0, 49) == 0)
                drain();
        end
        drain();
    endtask

    initial begin
        logic [CAT_BITS-1:0] phase_cat [4];
        sb = new();
        sb.chroma_type = CAT_RESET;
        sb.errors = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        phase_cat = '{2'd3, 2'd2, 2'd0, 2'd1};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of prefix and suffix, each mode, large me table
        send_item(make_item(OP_UE, 32'h8000_0000, 1'b0, 1'b0));
        send_item(make_item(OP_UE, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_item(make_item(OP_UE, 32'h0001_FFFF, 1'b0, 1'b0));
        send_item(make_item(OP_SE, 32'h0001_FFFF, 1'b0, 1'b1));
        send_item(make_item(OP_SE, 32'h0001_0000, 1'b0, 1'b0));
        send_item(make_item(OP_UE, 32'h0000_FFFF, 1'b0, 1'b0));
        send_item(make_item(OP_SE, 32'h0000_0000, 1'b0, 1'b0));
        send_item(make_item(OP_TE, 32'h0000_0000, 1'b0, 1'b1));
        send_item(make_item(OP_TE, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_item(make_item(OP_TE, 32'h4000_0000, 1'b0, 1'b0));
        send_item(make_item(OP_SE, 32'h4000_0000, 1'b0, 1'b0));
        send_item(make_item(OP_SE, 32'h6000_0000, 1'b0, 1'b0));
        send_item(make_item(OP_ME, 32'h0600_0000, 1'b0, 1'b0));
        send_item(make_item(OP_ME, 32'h0600_0000, 1'b1, 1'b0));
        send_item(make_item(OP_ME, 32'h0620_0000, 1'b1, 1'b0));
        send_item(make_item(OP_ME, 32'h8000_0000, 1'b1, 1'b0));
        drain();

        // Directed: small me table at both ends of its range
        write_chroma(2'd0);
        send_item(make_item(OP_ME, 32'h0800_0000, 1'b0, 1'b0));
        send_item(make_item(OP_ME, 32'h0800_0000, 1'b1, 1'b0));
        send_item(make_item(OP_ME, 32'h0880_0000, 1'b0, 1'b0));
        send_item(make_item(OP_ME, 32'h8000_0000, 1'b0, 1'b0));
        drain();
        write_chroma(2'd3);
        send_item(make_item(OP_ME, 32'h0800_0000, 1'b1, 1'b1));
        drain();

        // Random phases, one per chroma setting
        for (int p = 0; p < 4; p++) begin
            write_chroma(phase_cat[p]);
            random_items(95);
        end

        if (sb.pending_codes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_codes.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[exp_golomb_codeword_decoder_top] OK");
        else
            $display("[exp_golomb_codeword_decoder_top] ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/egd_pkg.sv
design/egd_decode.sv
design/exp_golomb_codeword_decoder_top.sv
sim/testbench.sv
